### hdl/fcca_pkg.sv
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared types and constants for the cluster chain allocator: beat payloads,
// action and status codes, table marker values and the controller states.
// ----------------------------------------------------------------------------
package fcca_pkg;

  // Default table depth and register reset value
  localparam int unsigned NumEntriesDef = 8192;
  localparam logic [13:0] LIMIT_RESET   = 14'd5101;

  // Table marker values
  localparam logic [15:0] MEDIA_MARK    = 16'hFFF8;
  localparam logic [15:0] END_MARK      = 16'hFFFF;
  localparam logic [15:0] CHAIN_END_MIN = 16'hFFF8;
  localparam logic [15:0] FREE_ENTRY    = 16'h0000;

  // First usable cluster
  localparam int unsigned FIRST_CLUSTER = 2;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_SET   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_FREE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CLUSTER = 2'd1,
    ST_NO_SPACE    = 2'd2,
    ST_LOOP        = 2'd3
  } status_e;

  typedef struct packed {
    action_e     action;
    logic [12:0] cluster;
    logic [15:0] value;
    logic [13:0] count;
  } in_item_t;

  typedef struct packed {
    logic [12:0] head_cluster;
    logic [15:0] entry_value;
    logic [13:0] freed_count;
    status_e     status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_ALLOC_END,
    S_READ_DATA,
    S_FREE_CHK,
    S_FREE_EVAL,
    S_RESP
  } state_e;

endpackage

### hdl/fcca_table.sv
// ----------------------------------------------------------------------------
// fcca_table
// Allocation table storage: one write port, one read port, read data
// registered. No reset; contents set by a clearing pass.
// ----------------------------------------------------------------------------
module fcca_table #(
  parameter int unsigned NUM_ENTRIES = fcca_pkg::NumEntriesDef,
  localparam int unsigned AW = $clog2(NUM_ENTRIES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [NUM_ENTRIES];
  logic [15:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fcca_ctrl.sv
// ----------------------------------------------------------------------------
// fcca_ctrl
// Sequencer for the allocation table: clearing pass after reset, first-fit
// chain allocation with streamed reads, entry set and read, and the chain
// free walk (each link read, then cleared if usable).
// ----------------------------------------------------------------------------
module fcca_ctrl #(
  parameter int unsigned NUM_ENTRIES = fcca_pkg::NumEntriesDef,
  localparam int unsigned AW = $clog2(NUM_ENTRIES),
  localparam int unsigned CW = $clog2(NUM_ENTRIES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item side
  input  logic                item_valid_i,
  input  fcca_pkg::in_item_t  item_i,
  output logic                item_stall_o,
  // effective cluster limit
  input  logic [CW-1:0]       lim_i,
  // result side
  output logic                res_valid_o,
  output fcca_pkg::out_item_t res_o,
  input  logic                res_take_i,
  // table ports
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [15:0]         mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  logic [15:0]         mem_rdata_i
);

  fcca_pkg::state_e   state_q, state_d;
  fcca_pkg::in_item_t item_q;
  logic [AW-1:0]      clr_q, clr_d;

  // allocation scan
  logic [CW-1:0]      scan_q, scan_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      pend_addr_q, pend_addr_d;
  logic [AW-1:0]      prev_q, prev_d;
  logic [13:0]        got_q, got_d;
  logic [13:0]        want_q, want_d;

  // free walk
  logic [15:0]        cur_q, cur_d;
  logic [CW-1:0]      steps_q, steps_d;

  // result fields
  logic [12:0]        head_q, head_d;
  logic [15:0]        entry_q, entry_d;
  logic [13:0]        freed_q, freed_d;
  fcca_pkg::status_e  stat_q, stat_d;

  logic               found;
  logic               cur_usable;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcca_pkg::S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (state_q == fcca_pkg::S_IDLE && item_valid_i) begin
      item_q <= item_i;
    end
    scan_q      <= scan_d;
    pend_addr_q <= pend_addr_d;
    prev_q      <= prev_d;
    got_q       <= got_d;
    want_q      <= want_d;
    cur_q       <= cur_d;
    steps_q     <= steps_d;
    head_q      <= head_d;
    entry_q     <= entry_d;
    freed_q     <= freed_d;
    stat_q      <= stat_d;
  end

  assign found      = pend_q && (mem_rdata_i == fcca_pkg::FREE_ENTRY);
  assign cur_usable = (32'(cur_q) >= fcca_pkg::FIRST_CLUSTER) && (32'(cur_q) < 32'(lim_i));

  // Next state and table access
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    prev_d      = prev_q;
    got_d       = got_q;
    want_d      = want_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    head_d      = head_q;
    entry_d     = entry_q;
    freed_d     = freed_q;
    stat_d      = stat_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = fcca_pkg::FREE_ENTRY;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      // write media mark, end mark, then free entries over the whole table
      fcca_pkg::S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        if (clr_q == AW'(0)) begin
          mem_wdata_o = fcca_pkg::MEDIA_MARK;
        end else if (clr_q == AW'(1)) begin
          mem_wdata_o = fcca_pkg::END_MARK;
        end
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_ENTRIES - 1)) begin
          state_d = fcca_pkg::S_IDLE;
        end
      end

      fcca_pkg::S_IDLE: begin
        if (item_valid_i) begin
          state_d = fcca_pkg::S_DECODE;
        end
      end

      fcca_pkg::S_DECODE: begin
        head_d  = '0;
        entry_d = '0;
        freed_d = '0;
        stat_d  = fcca_pkg::ST_OK;
        unique case (item_q.action)
          fcca_pkg::ACT_ALLOC: begin
            scan_d  = CW'(fcca_pkg::FIRST_CLUSTER);
            got_d   = '0;
            want_d  = (item_q.count == '0) ? 14'd1 : item_q.count;
            state_d = fcca_pkg::S_ALLOC;
          end
          fcca_pkg::ACT_SET: begin
            if ((32'(item_q.cluster) < fcca_pkg::FIRST_CLUSTER) ||
                (32'(item_q.cluster) >= 32'(lim_i))) begin
              stat_d = fcca_pkg::ST_BAD_CLUSTER;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = AW'(item_q.cluster);
              mem_wdata_o = item_q.value;
            end
            state_d = fcca_pkg::S_RESP;
          end
          fcca_pkg::ACT_READ: begin
            if (32'(item_q.cluster) >= NUM_ENTRIES) begin
              stat_d  = fcca_pkg::ST_BAD_CLUSTER;
              state_d = fcca_pkg::S_RESP;
            end else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(item_q.cluster);
              state_d     = fcca_pkg::S_READ_DATA;
            end
          end
          fcca_pkg::ACT_FREE: begin
            cur_d   = 16'(item_q.cluster);
            steps_d = '0;
            state_d = fcca_pkg::S_FREE_CHK;
          end
          default: state_d = fcca_pkg::S_RESP;
        endcase
      end

      // streamed first-fit scan: issue one read per cycle, judge the returned one
      fcca_pkg::S_ALLOC: begin
        if (found) begin
          if (got_q != '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = prev_q;
            mem_wdata_o = 16'(pend_addr_q);
          end else begin
            head_d = 13'(pend_addr_q);
          end
          prev_d = pend_addr_q;
          got_d  = got_q + 14'd1;
        end
        if (found && (got_q + 14'd1 == want_q)) begin
          state_d = fcca_pkg::S_ALLOC_END;
        end else if (scan_q < lim_i) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(scan_q);
          pend_d      = 1'b1;
          pend_addr_d = AW'(scan_q);
          scan_d      = scan_q + CW'(1);
        end else if (!pend_q) begin
          // out of space; taken clusters stay linked
          stat_d = fcca_pkg::ST_NO_SPACE;
          head_d = '0;
          state_d = (got_q != '0) ? fcca_pkg::S_ALLOC_END : fcca_pkg::S_RESP;
        end
      end

      // terminate the chain at its last cluster
      fcca_pkg::S_ALLOC_END: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = prev_q;
        mem_wdata_o = fcca_pkg::END_MARK;
        state_d     = fcca_pkg::S_RESP;
      end

      fcca_pkg::S_READ_DATA: begin
        entry_d = mem_rdata_i;
        state_d = fcca_pkg::S_RESP;
      end

      // walk guard checks, then fetch the current entry
      fcca_pkg::S_FREE_CHK: begin
        if (cur_q >= fcca_pkg::CHAIN_END_MIN) begin
          state_d = fcca_pkg::S_RESP;
        end else if (32'(cur_q) >= NUM_ENTRIES) begin
          stat_d  = fcca_pkg::ST_BAD_CLUSTER;
          state_d = fcca_pkg::S_RESP;
        end else if (32'(steps_q) >= NUM_ENTRIES) begin
          stat_d  = fcca_pkg::ST_LOOP;
          state_d = fcca_pkg::S_RESP;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(cur_q);
          steps_d     = steps_q + CW'(1);
          state_d     = fcca_pkg::S_FREE_EVAL;
        end
      end

      // follow the link, clear the entry if it is in the usable range
      fcca_pkg::S_FREE_EVAL: begin
        if (cur_usable) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AW'(cur_q);
          mem_wdata_o = fcca_pkg::FREE_ENTRY;
          if (mem_rdata_i != fcca_pkg::FREE_ENTRY) begin
            freed_d = freed_q + 14'd1;
          end
        end
        cur_d   = mem_rdata_i;
        state_d = fcca_pkg::S_FREE_CHK;
      end

      fcca_pkg::S_RESP: begin
        if (res_take_i) begin
          state_d = fcca_pkg::S_IDLE;
        end
      end

      default: state_d = fcca_pkg::S_IDLE;
    endcase
  end

  assign item_stall_o           = (state_q != fcca_pkg::S_IDLE);
  assign res_valid_o            = (state_q == fcca_pkg::S_RESP);
  assign res_o.head_cluster     = head_q;
  assign res_o.entry_value      = entry_q;
  assign res_o.freed_count      = freed_q;
  assign res_o.status           = stat_q;

endmodule

### hdl/fat_cluster_chain_allocator_unit.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_unit
// Top level: limit register, effective limit, table, sequencer and the output
// register that holds a finished result beat until it is taken.
// ----------------------------------------------------------------------------
// Reset: a clearing pass writes every table entry, stall high.
// Set writes a valid cluster's entry at decode; read returns registered table data.
// Free reads, then clears, each usable link walked. Allocate scans first fit,
// one table read per cycle. One item in flight; one write and one read port.
// The output register lets the next item be taken while a result waits.
module fat_cluster_chain_allocator_unit #(
  parameter int unsigned NUM_ENTRIES = fcca_pkg::NumEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [13:0]         cfg_wdata_i,
  // input beats
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fcca_pkg::in_item_t  in_i,
  // output beats
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcca_pkg::out_item_t out_o
);

  localparam int unsigned AW = $clog2(NUM_ENTRIES);
  localparam int unsigned CW = $clog2(NUM_ENTRIES + 1);

  logic [13:0]         limit_q;
  logic [CW-1:0]       lim;
  logic                res_valid;
  fcca_pkg::out_item_t res;
  logic                res_take;
  logic                out_valid_q;
  fcca_pkg::out_item_t out_q;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [15:0]         mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [15:0]         mem_rdata;

  // Cluster limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= fcca_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Usable limit is the smaller of the register and the table depth
  assign lim = (32'(limit_q) > NUM_ENTRIES) ? CW'(NUM_ENTRIES) : CW'(limit_q);

  fcca_table #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fcca_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_i),
    .item_i       (in_i),
    .item_stall_o (in_stall_o),
    .lim_i        (lim),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_take_i   (res_take),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Output register: load when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hdl/fcca_checker.sv
// ----------------------------------------------------------------------------
// fcca_checker
// Port-level checks for the cluster chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fcca_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fcca_pkg::out_item_t out_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result beat changed");

  // One item at a time: an accepted beat closes the input side
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // A result with any failing status never reports a head cluster
  a_fail_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != fcca_pkg::ST_OK) |-> out_o.head_cluster == 13'd0)
    else $error("head cluster on failed action");

  // A reported head excludes read and free fields
  a_head_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.head_cluster != 13'd0) |->
      out_o.entry_value == 16'd0 && out_o.freed_count == 14'd0)
    else $error("allocation result mixed with other fields");

  // Loop guard only from a free walk, which leaves the read field untouched
  a_loop_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status == fcca_pkg::ST_LOOP) |-> out_o.entry_value == 16'd0)
    else $error("entry value on loop guard result");

endmodule

bind fat_cluster_chain_allocator_unit fcca_checker u_fcca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

### tb/sv/fat_cluster_chain_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_unit_tb
// Self-checking bench for the cluster chain allocator. A shadow copy of the
// allocation table predicts every result beat. Directed beats cover the
// table markers, rejected sets, broken links, the loop guard, a full-table
// allocation and limits below three. Random phases then sweep the cluster
// limit upward under varied sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_unit_tb;
  import fcca_pkg::*;

  localparam int unsigned TABLE_DEPTH = NumEntriesDef;

  // Shadow allocation table and queue of predicted result beats
  class cluster_table_tracker;
    logic [15:0]  fat_entries [TABLE_DEPTH];
    int unsigned  limit_reg;
    out_item_t    pending_results [$];
    int unsigned  chain_heads [$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  action_hits [4];
    int unsigned  status_hits [4];

    function new();
      foreach (fat_entries[i]) fat_entries[i] = FREE_ENTRY;
      fat_entries[0] = MEDIA_MARK;
      fat_entries[1] = END_MARK;
      limit_reg = LIMIT_RESET;
    endfunction

    function void set_limit(int unsigned v);
      limit_reg = v & 32'h3FFF;
    endfunction

    function int unsigned usable();
      return (limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : limit_reg;
    endfunction

    // Applies one action to the shadow table and returns the result beat
    function out_item_t apply_action(in_item_t it);
      out_item_t   r;
      int unsigned lim, want, pos, prev, got, first, cur, nxt, steps, freed;
      r     = '0;
      lim   = usable();
      case (it.action)
        ACT_ALLOC: begin
          want = (it.count == 0) ? 1 : it.count;
          pos  = FIRST_CLUSTER;
          prev = 0;
          got  = 0;
          first = 0;
          while (got < want) begin
            while (pos < lim && fat_entries[pos] != FREE_ENTRY) pos++;
            if (pos >= lim) begin
              r.status = ST_NO_SPACE;
              break;
            end
            fat_entries[pos] = END_MARK;
            if (got == 0) first = pos;
            else fat_entries[prev] = 16'(pos);
            prev = pos;
            got++;
            pos++;
          end
          // a partial chain stays allocated, so keep its head for later frees
          if (got > 0) chain_heads.push_back(first);
          if (r.status == ST_OK) r.head_cluster = 13'(first);
        end
        ACT_SET: begin
          if (it.cluster < FIRST_CLUSTER || it.cluster >= lim) r.status = ST_BAD_CLUSTER;
          else fat_entries[it.cluster] = it.value;
        end
        ACT_READ: begin
          if (it.cluster >= TABLE_DEPTH) r.status = ST_BAD_CLUSTER;
          else r.entry_value = fat_entries[it.cluster];
        end
        default: begin
          cur   = it.cluster;
          steps = 0;
          freed = 0;
          // walk until an end marker; entries outside the usable range are only followed
          while (cur < CHAIN_END_MIN) begin
            if (cur >= TABLE_DEPTH) begin
              r.status = ST_BAD_CLUSTER;
              break;
            end
            if (steps >= TABLE_DEPTH) begin
              r.status = ST_LOOP;
              break;
            end
            steps++;
            nxt = fat_entries[cur];
            if (cur >= FIRST_CLUSTER && cur < lim) begin
              if (fat_entries[cur] != FREE_ENTRY) freed++;
              fat_entries[cur] = FREE_ENTRY;
            end
            cur = nxt;
          end
          r.freed_count = 14'(freed);
        end
      endcase
      return r;
    endfunction

    function void note_request(in_item_t it);
      out_item_t r;
      r = apply_action(it);
      action_hits[it.action]++;
      status_hits[r.status]++;
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
        return;
      end
      exp = pending_results.pop_front();
      results_checked++;
      if (got.head_cluster !== exp.head_cluster)
        report_mismatch($sformatf("head_cluster got %0d exp %0d",
                                  got.head_cluster, exp.head_cluster));
      if (got.entry_value !== exp.entry_value)
        report_mismatch($sformatf("entry_value got %h exp %h",
                                  got.entry_value, exp.entry_value));
      if (got.freed_count !== exp.freed_count)
        report_mismatch($sformatf("freed_count got %0d exp %0d",
                                  got.freed_count, exp.freed_count));
      if (got.status !== exp.status)
        report_mismatch($sformatf("status got %0d exp %0d", got.status, exp.status));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [13:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  cluster_table_tracker tracker;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  always #10 clk = ~clk;

  fat_cluster_chain_allocator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_data)
  );

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result beats are checked at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // Offer one beat, hold it until taken, then maybe leave a gap
  task automatic send_beat(action_e act, int unsigned cl, int unsigned val,
                           int unsigned cnt);
    in_item_t    it;
    int unsigned gap;
    it.action  = act;
    it.cluster = 13'(cl);
    it.value   = 16'(val);
    it.count   = 14'(cnt);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    tracker.note_request(it);
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender goes quiet until every predicted beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= 14'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_limit(v);
  endtask

  function automatic int unsigned pick_cluster(int unsigned lim);
    if (lim > FIRST_CLUSTER && $urandom_range(99) < 85)
      return $urandom_range(FIRST_CLUSTER, lim - 1);
    return $urandom_range(0, TABLE_DEPTH - 1);
  endfunction

  // One random action, or a short run of reads along a chain
  task automatic random_step(inout int unsigned sent);
    int unsigned lim, pick, cl, val, cnt, idx, hop;
    lim  = tracker.usable();
    pick = $urandom_range(99);
    if (pick < 30) begin
      if (lim <= 256 && $urandom_range(99) < 15) cnt = $urandom_range(0, 16383);
      else cnt = $urandom_range(0, 8);
      send_beat(ACT_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 65535), cnt);
      sent++;
    end else if (pick < 50) begin
      if (tracker.chain_heads.size() > 0)
        cl = tracker.chain_heads[$urandom_range(0, tracker.chain_heads.size() - 1)];
      else
        cl = pick_cluster(lim);
      for (hop = $urandom_range(1, 6); hop > 0; hop--) begin
        send_beat(ACT_READ, cl, $urandom_range(0, 65535), $urandom_range(0, 16383));
        sent++;
        val = tracker.fat_entries[cl];
        if (val >= TABLE_DEPTH) break;
        cl = val;
      end
    end else if (pick < 70) begin
      if (tracker.chain_heads.size() > 0) begin
        idx = $urandom_range(0, tracker.chain_heads.size() - 1);
        cl  = tracker.chain_heads[idx];
        tracker.chain_heads.delete(idx);
      end else begin
        cl = pick_cluster(lim);
      end
      send_beat(ACT_FREE, cl, $urandom_range(0, 65535), $urandom_range(0, 16383));
      sent++;
    end else if (pick < 85) begin
      pick = $urandom_range(99);
      if (pick < 35) val = (lim > FIRST_CLUSTER) ? $urandom_range(FIRST_CLUSTER, lim - 1) : 0;
      else if (pick < 55) val = $urandom_range(CHAIN_END_MIN, END_MARK);
      else if (pick < 70) val = FREE_ENTRY;
      else val = $urandom_range(0, 65535);
      send_beat(ACT_SET, pick_cluster(lim), val, $urandom_range(0, 16383));
      sent++;
    end else if (pick < 95) begin
      send_beat(ACT_READ, pick_cluster(lim), $urandom_range(0, 65535),
                $urandom_range(0, 16383));
      sent++;
    end else begin
      send_beat(ACT_FREE, pick_cluster(lim), $urandom_range(0, 65535),
                $urandom_range(0, 16383));
      sent++;
    end
  endtask

  // mode 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both light
  task automatic run_phase(int unsigned lim, int unsigned beats, int unsigned mode);
    int unsigned sent;
    bit          held, paused;
    write_limit(lim);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 70; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 24; stall_pct = 24; end
    endcase
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < beats) begin
      // back up the block behind a long receiver hold-off
      if (mode == 0 && !held && sent >= beats / 3) begin
        hold_cycles = 500;
        held = 1'b1;
      end
      if (mode == 1 && !paused && sent >= beats / 2) begin
        drain_results();
        paused = 1'b1;
      end
      random_step(sent);
    end
  endtask

  initial begin
    int unsigned part_head;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // table clearing pass holds stall high
    do @(posedge clk); while (in_stall);

    // Directed: markers, first-fit, rejected sets, broken links
    send_beat(ACT_READ, 0, 0, 0);
    send_beat(ACT_READ, 1, 0, 0);
    send_beat(ACT_READ, 8191, 0, 0);
    send_beat(ACT_ALLOC, 0, 0, 0);
    send_beat(ACT_ALLOC, 0, 0, 3);
    send_beat(ACT_READ, 3, 0, 0);
    send_beat(ACT_SET, 0, 16'h1234, 0);
    send_beat(ACT_SET, 1, 16'h1234, 0);
    send_beat(ACT_SET, 5101, 16'h1234, 0);
    send_beat(ACT_SET, 5100, END_MARK, 0);
    send_beat(ACT_SET, 10, 16'hA5A5, 0);
    send_beat(ACT_FREE, 10, 0, 0);
    send_beat(ACT_FREE, 3, 0, 0);
    send_beat(ACT_FREE, 0, 0, 0);
    send_beat(ACT_FREE, 5100, 0, 0);
    send_beat(ACT_SET, 20, 6000, 0);
    send_beat(ACT_FREE, 20, 0, 0);

    // Loop guard: a cycle left above a lowered limit is not cleared until the limit rises
    write_limit(8192);
    send_beat(ACT_SET, 8000, 8001, 0);
    send_beat(ACT_SET, 8001, 8000, 0);
    write_limit(100);
    send_beat(ACT_FREE, 8000, 0, 0);
    write_limit(8192);
    send_beat(ACT_FREE, 8000, 0, 0);

    // Full-table allocation runs out, then the partial chain is freed
    send_beat(ACT_ALLOC, 0, 0, 8192);
    send_beat(ACT_READ, 8191, 0, 0);
    part_head = tracker.chain_heads.pop_back();
    send_beat(ACT_FREE, part_head, 0, 0);
    send_beat(ACT_SET, 8191, END_MARK, 0);
    send_beat(ACT_FREE, 8191, 0, 0);

    // Limits below three leave no usable cluster
    write_limit(2);
    send_beat(ACT_ALLOC, 0, 0, 1);
    send_beat(ACT_SET, 2, 5, 0);
    write_limit(0);
    send_beat(ACT_ALLOC, 0, 0, 0);

    // Random phases, limit sweeping upward so stale links stay free
    run_phase(3, 150, 0);
    run_phase(64, 300, 1);
    run_phase(200, 350, 2);
    run_phase(1000, 300, 3);
    run_phase(5101, 200, 0);
    run_phase(8192, 250, 1);
    run_phase(12000, 200, 2);

    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d beats: %0d alloc, %0d set, %0d read, %0d free; limits 0 to 12000",
             tracker.results_checked, tracker.action_hits[ACT_ALLOC],
             tracker.action_hits[ACT_SET], tracker.action_hits[ACT_READ],
             tracker.action_hits[ACT_FREE]);
    $display("Statuses: %0d ok, %0d bad cluster, %0d out of space, %0d loop guard",
             tracker.status_hits[ST_OK], tracker.status_hits[ST_BAD_CLUSTER],
             tracker.status_hits[ST_NO_SPACE], tracker.status_hits[ST_LOOP]);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #200_000_000;
    $display("Timeout: %0d result beats still outstanding",
             tracker.pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
